@@ sv/bgle_pkg.sv @@
// Shared types and constants of the boolean gate-list evaluator.
`timescale 1ns / 1ps
`default_nettype none

package bgle_pkg;

  localparam int WIRE_W = 12;
  localparam int CNT_W  = 13;

  localparam int WIRE_ZERO = 0;
  localparam int WIRE_ONE  = 1;
  localparam int WIRE_BASE = 2;

  localparam logic [CNT_W-1:0] WIRE_COUNT_RESET = 13'd4096;

  typedef enum logic [1:0] {
    OP_SET_INPUT = 2'd0,
    OP_EVAL_GATE = 2'd1,
    OP_READ_WIRE = 2'd2
  } op_t;

  localparam logic [1:0] KIND_AND = 2'd0;
  localparam logic [1:0] KIND_XOR = 2'd1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE = 2'd2;

  typedef struct packed {
    logic       bit_value;
    logic       operand_a_bit;
    logic       operand_b_bit;
    logic       trace_and_bit;
    logic [1:0] status;
  } res_t;

endpackage

`default_nettype wire

@@ sv/bgle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bgle_ram #(
  parameter int DATA_W = 1,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ sv/bgle_eval.sv @@
// Range checks, operand selection with forwarding, gate evaluation and write request.
`timescale 1ns / 1ps
`default_nettype none

module bgle_eval #(
  parameter int WIRE_DEPTH = 4096,
  parameter int ADDR_W     = 12
) (
  input  wire logic [bgle_pkg::CNT_W-1:0]  wire_count,
  input  wire logic [1:0]                  op,
  input  wire logic [1:0]                  gate_kind,
  input  wire logic [bgle_pkg::WIRE_W-1:0] wire_a,
  input  wire logic [bgle_pkg::WIRE_W-1:0] wire_b,
  input  wire logic [bgle_pkg::WIRE_W-1:0] wire_dest,
  input  wire logic [bgle_pkg::WIRE_W-1:0] input_index,
  input  wire logic                        input_bit,
  input  wire logic                        ram_a_bit,
  input  wire logic                        ram_b_bit,
  input  wire logic                        fwd_valid,
  input  wire logic [ADDR_W-1:0]           fwd_addr,
  input  wire logic                        fwd_bit,
  output bgle_pkg::res_t                   res,
  output logic                             wr_en,
  output logic      [ADDR_W-1:0]           wr_addr,
  output logic                             wr_bit
);

  import bgle_pkg::*;

  localparam int CMP_W = (ADDR_W + 1 > CNT_W) ? ADDR_W + 1 : CNT_W;

  logic [CMP_W-1:0] cnt_x;
  logic [CMP_W-1:0] depth_x;
  logic [CMP_W-1:0] wa_x;
  logic [CMP_W-1:0] wb_x;
  logic [CMP_W-1:0] wd_x;
  logic [CMP_W-1:0] win_x;
  logic             wa_ok;
  logic             wb_ok;
  logic             wd_ok;
  logic             win_ok;
  logic             a_bit;
  logic             b_bit;

  assign cnt_x   = CMP_W'(wire_count);
  assign depth_x = CMP_W'(WIRE_DEPTH);
  assign wa_x    = CMP_W'(wire_a);
  assign wb_x    = CMP_W'(wire_b);
  assign wd_x    = CMP_W'(wire_dest);
  assign win_x   = CMP_W'(input_index) + CMP_W'(WIRE_BASE);

  assign wa_ok  = (wa_x < cnt_x) && (wa_x < depth_x);
  assign wb_ok  = (wb_x < cnt_x) && (wb_x < depth_x);
  assign wd_ok  = (wd_x < cnt_x) && (wd_x < depth_x);
  assign win_ok = (win_x < cnt_x) && (win_x < depth_x);

  // Wires zero and one are constants; otherwise the write made by the
  // previous word wins over the stale memory read.
  always_comb begin
    if (wa_x == CMP_W'(WIRE_ZERO)) begin
      a_bit = 1'b0;
    end else if (wa_x == CMP_W'(WIRE_ONE)) begin
      a_bit = 1'b1;
    end else if (fwd_valid && (fwd_addr == wa_x[ADDR_W-1:0])) begin
      a_bit = fwd_bit;
    end else begin
      a_bit = ram_a_bit;
    end
    if (wb_x == CMP_W'(WIRE_ZERO)) begin
      b_bit = 1'b0;
    end else if (wb_x == CMP_W'(WIRE_ONE)) begin
      b_bit = 1'b1;
    end else if (fwd_valid && (fwd_addr == wb_x[ADDR_W-1:0])) begin
      b_bit = fwd_bit;
    end else begin
      b_bit = ram_b_bit;
    end
  end

  always_comb begin
    res     = '0;
    wr_en   = 1'b0;
    wr_addr = wd_x[ADDR_W-1:0];
    wr_bit  = 1'b0;
    unique case (op)
      OP_SET_INPUT: begin
        wr_addr = win_x[ADDR_W-1:0];
        wr_bit  = input_bit;
        if (win_ok) begin
          wr_en = 1'b1;
        end else begin
          res.status = ST_RANGE;
        end
      end
      OP_EVAL_GATE: begin
        if (!(wa_ok && wb_ok && wd_ok)) begin
          res.status = ST_RANGE;
        end else begin
          res.operand_a_bit = a_bit;
          res.operand_b_bit = b_bit;
          case (gate_kind)
            KIND_AND: begin
              res.bit_value     = a_bit & b_bit;
              res.trace_and_bit = 1'b1;
              wr_bit            = a_bit & b_bit;
              wr_en             = (wd_x >= CMP_W'(WIRE_BASE));
            end
            KIND_XOR: begin
              res.bit_value = a_bit ^ b_bit;
              wr_bit        = a_bit ^ b_bit;
              wr_en         = (wd_x >= CMP_W'(WIRE_BASE));
            end
            default: begin
              res.status = ST_BAD_TYPE;
            end
          endcase
        end
      end
      OP_READ_WIRE: begin
        if (wa_ok) begin
          res.bit_value = a_bit;
        end else begin
          res.status = ST_RANGE;
        end
      end
      default: begin
        res.status = ST_BAD_TYPE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/boolean_gate_list_evaluator.sv @@
// Top level of the boolean gate-list evaluator: wire store, pipeline and handshakes.
//
// Usage: words enter on the in_ channel, one per cycle at full rate, and each
// word gives exactly one result word on the out_ channel, in order. in_tuser
// carries the operation and gate kind, in_tdata the wire numbers, the input
// number and the input bit. A word can load a circuit input, evaluate one AND
// or XOR gate or read back one wire; out_tdata returns the bits and out_tuser
// the status.
// From acceptance a word goes through the evaluation stage registers to the
// result register that drives out_tvalid: the wire store is read as the word is
// accepted, and evaluation plus the write-back happen in the evaluation stage.
// A gate may use the wire written by the word just before it, since that write
// is forwarded. Throughput is one word per cycle while results are taken, set
// by the two read ports and the one write port of the wire store. After reset
// the store is cleared one wire per cycle, and in_tready stays low until that
// is done; cfg_wr_en is taken at any time and wire_count resets to 4096. When
// the receiver stalls, the result register holds its word and one more word
// can sit in the evaluation stage; in_tready then drops until out_tready returns.
`timescale 1ns / 1ps
`default_nettype none

module boolean_gate_list_evaluator #(
  parameter int WIRE_DEPTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // Fields from bit 0: wire_a[11:0], wire_b[23:12], wire_dest[35:24],
  // input_index[47:36], input_bit[48], zero fill.
  input  wire logic [55:0] in_tdata,
  // Fields from bit 0: op[1:0], gate_kind[3:2].
  input  wire logic [3:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // Fields from bit 0: bit_value, operand_a_bit, operand_b_bit, trace_and_bit,
  // zero fill.
  output logic      [7:0]  out_tdata,
  // Fields from bit 0: status[1:0].
  output logic      [1:0]  out_tuser,
  input  wire logic        cfg_wr_en,
  input  wire logic [12:0] cfg_wr_data
);

  import bgle_pkg::*;

  localparam int ADDR_W = (WIRE_DEPTH > 1) ? $clog2(WIRE_DEPTH) : 1;
  localparam int IDX_W  = (ADDR_W > WIRE_W) ? ADDR_W : WIRE_W;

  logic [CNT_W-1:0]  wire_count_r;

  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic              s1_valid_r;
  logic [1:0]        s1_op_r;
  logic [1:0]        s1_kind_r;
  logic [WIRE_W-1:0] s1_wa_r;
  logic [WIRE_W-1:0] s1_wb_r;
  logic [WIRE_W-1:0] s1_wd_r;
  logic [WIRE_W-1:0] s1_idx_r;
  logic              s1_ibit_r;

  logic              fwd_valid_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  logic              fwd_bit_r;

  logic              out_valid_r;
  res_t              out_res_r;

  logic              in_fire;
  logic              s1_fire;
  logic [IDX_W-1:0]  in_wa_x;
  logic [IDX_W-1:0]  in_wb_x;
  logic              ram_a_bit;
  logic              ram_b_bit;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_wdata;

  res_t              ev_res;
  logic              ev_wr_en;
  logic [ADDR_W-1:0] ev_wr_addr;
  logic              ev_wr_bit;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_busy_r && (!s1_valid_r || s1_fire);
  assign in_fire   = in_tvalid && in_tready;

  assign in_wa_x = IDX_W'(in_tdata[11:0]);
  assign in_wb_x = IDX_W'(in_tdata[23:12]);

  assign ram_we    = clr_busy_r || (s1_fire && ev_wr_en);
  assign ram_waddr = clr_busy_r ? clr_addr_r : ev_wr_addr;
  assign ram_wdata = clr_busy_r ? 1'b0 : ev_wr_bit;

  bgle_ram #(
    .DATA_W (1),
    .DEPTH  (WIRE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_wa_x[ADDR_W-1:0]),
    .rdata (ram_a_bit)
  );

  bgle_ram #(
    .DATA_W (1),
    .DEPTH  (WIRE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_wb_x[ADDR_W-1:0]),
    .rdata (ram_b_bit)
  );

  bgle_eval #(
    .WIRE_DEPTH (WIRE_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_eval (
    .wire_count  (wire_count_r),
    .op          (s1_op_r),
    .gate_kind   (s1_kind_r),
    .wire_a      (s1_wa_r),
    .wire_b      (s1_wb_r),
    .wire_dest   (s1_wd_r),
    .input_index (s1_idx_r),
    .input_bit   (s1_ibit_r),
    .ram_a_bit   (ram_a_bit),
    .ram_b_bit   (ram_b_bit),
    .fwd_valid   (fwd_valid_r),
    .fwd_addr    (fwd_addr_r),
    .fwd_bit     (fwd_bit_r),
    .res         (ev_res),
    .wr_en       (ev_wr_en),
    .wr_addr     (ev_wr_addr),
    .wr_bit      (ev_wr_bit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wire_count_r <= WIRE_COUNT_RESET;
    end else if (cfg_wr_en) begin
      wire_count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(WIRE_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // The memory read taken with a new word misses the write made at the same
  // edge, so that write is kept for the evaluation stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r  <= 1'b1;
      fwd_valid_r <= s1_fire && ev_wr_en;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_tuser[1:0];
      s1_kind_r  <= in_tuser[3:2];
      s1_wa_r    <= in_tdata[11:0];
      s1_wb_r    <= in_tdata[23:12];
      s1_wd_r    <= in_tdata[35:24];
      s1_idx_r   <= in_tdata[47:36];
      s1_ibit_r  <= in_tdata[48];
      fwd_addr_r <= ev_wr_addr;
      fwd_bit_r  <= ev_wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= ev_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.trace_and_bit, out_res_r.operand_b_bit,
                       out_res_r.operand_a_bit, out_res_r.bit_value};
  assign out_tuser  = out_res_r.status;

endmodule

`default_nettype wire

@@ sv/bgle_checker.sv @@
// Port-level checks of the boolean gate-list evaluator and their binding.
`timescale 1ns / 1ps
`default_nettype none

module bgle_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic [1:0]  out_tuser
);

  import bgle_pkg::*;

  // The clear pass keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready during store clear");

  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word right after reset");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_RANGE)) |-> (out_tdata == 8'h00))
    else $error("out of range result carries nonzero bits");

  a_bad_type_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_BAD_TYPE)) |-> (!out_tdata[0] && !out_tdata[3]))
    else $error("invalid type result carries gate bits");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result word changed");

endmodule

bind boolean_gate_list_evaluator bgle_checker u_bgle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

@@ verif/tb_boolean_gate_list_evaluator.sv @@
// Self-checking testbench of the boolean gate-list evaluator with its own wire-store predictor.
`timescale 1ns / 1ps

module tb_boolean_gate_list_evaluator;
  import bgle_pkg::*;

  localparam int STORE_DEPTH = 4096;
  localparam int STALL_LIMIT = 20000;
  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam logic [1:0] GATE_BAD_LO = 2'd2;
  localparam logic [1:0] GATE_BAD_HI = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic [3:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [12:0] cfg_wr_data = '0;

  bit wire_store [STORE_DEPTH];
  logic [12:0] wire_limit;
  res_t pending_results [$];
  int mismatch_count = 0;
  int stall_cycles = 0;
  int ready_hold = 0;
  bit idle_on = 1'b1;
  int win_lo = 2;
  int win_span = 1;

  boolean_gate_list_evaluator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic bit wire_ok(int w);
    return w < int'(wire_limit) && w < STORE_DEPTH;
  endfunction

  function automatic bit wire_value(int w);
    if (w == WIRE_ZERO) return 1'b0;
    if (w == WIRE_ONE) return 1'b1;
    return wire_store[w];
  endfunction

  function automatic void store_wire(int w, bit v);
    if (w >= WIRE_BASE) wire_store[w] = v;
  endfunction

  function automatic res_t evaluate_word(logic [1:0] op, logic [1:0] kind, logic [11:0] wa,
                                         logic [11:0] wb, logic [11:0] wd, logic [11:0] idx,
                                         logic ibit);
    res_t r;
    int w;
    r = '0;
    case (op)
      OP_SET_INPUT: begin
        w = int'(idx) + WIRE_BASE;
        if (wire_ok(w)) store_wire(w, ibit);
        else r.status = ST_RANGE;
      end
      OP_EVAL_GATE: begin
        if (!wire_ok(int'(wa)) || !wire_ok(int'(wb)) || !wire_ok(int'(wd))) begin
          r.status = ST_RANGE;
        end else begin
          r.operand_a_bit = wire_value(int'(wa));
          r.operand_b_bit = wire_value(int'(wb));
          if (kind == KIND_AND) begin
            r.bit_value = r.operand_a_bit & r.operand_b_bit;
            r.trace_and_bit = 1'b1;
            store_wire(int'(wd), r.bit_value);
          end else if (kind == KIND_XOR) begin
            r.bit_value = r.operand_a_bit ^ r.operand_b_bit;
            store_wire(int'(wd), r.bit_value);
          end else begin
            r.status = ST_BAD_TYPE;
          end
        end
      end
      OP_READ_WIRE: begin
        if (wire_ok(int'(wa))) r.bit_value = wire_value(int'(wa));
        else r.status = ST_RANGE;
      end
      default: r.status = ST_BAD_TYPE;
    endcase
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(logic [1:0] op, logic [1:0] kind, logic [11:0] wa, logic [11:0] wb,
                           logic [11:0] wd, logic [11:0] idx, logic ibit);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {kind, op};
    in_tdata <= {7'd0, ibit, idx, wd, wb, wa};
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    pending_results.push_back(evaluate_word(op, kind, wa, wb, wd, idx, ibit));
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_wire_count(logic [12:0] count);
    wait_results_drained();
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= count;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    wire_limit = count;
  endtask

  function automatic void choose_window();
    int lim;
    lim = (int'(wire_limit) < STORE_DEPTH) ? int'(wire_limit) : STORE_DEPTH;
    if (lim > WIRE_BASE) begin
      win_span = (lim - WIRE_BASE < 32) ? lim - WIRE_BASE : 32;
      win_lo = $urandom_range(WIRE_BASE, lim - win_span);
    end else begin
      win_lo = WIRE_BASE;
      win_span = 1;
    end
  endfunction

  function automatic logic [11:0] pick_wire();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 12'(r);
    if (r == 2) return 12'($urandom_range(0, 4095));
    return 12'(win_lo + $urandom_range(0, win_span - 1));
  endfunction

  task automatic send_random_word(bit noise);
    logic [11:0] w;
    logic [11:0] idx;
    int r;
    if (noise) begin
      send_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 12'($urandom),
                12'($urandom), 12'($urandom), 12'($urandom), 1'($urandom));
    end else begin
      r = $urandom_range(0, 99);
      w = pick_wire();
      idx = (w >= WIRE_BASE) ? w - 12'(WIRE_BASE) : 12'($urandom_range(0, 4095));
      if (r < 25) begin
        send_word(OP_SET_INPUT, 2'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                  idx, 1'($urandom));
      end else if (r < 80) begin
        send_word(OP_EVAL_GATE, (r < 78) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3)),
                  pick_wire(), pick_wire(), w, 12'($urandom), 1'($urandom));
      end else begin
        send_word(OP_READ_WIRE, 2'($urandom), w, 12'($urandom), 12'($urandom), 12'($urandom),
                  1'($urandom));
      end
    end
  endtask

  task automatic test_constant_wires();
    set_wire_count(13'd4096);
    send_word(OP_READ_WIRE, KIND_AND, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    send_word(OP_READ_WIRE, KIND_AND, 12'd1, 12'd0, 12'd0, 12'd0, 1'b0);
    send_word(OP_SET_INPUT, KIND_AND, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1);
    send_word(OP_EVAL_GATE, KIND_AND, 12'd1, 12'd2, 12'd0, 12'd0, 1'b0);
    send_word(OP_EVAL_GATE, KIND_XOR, 12'd0, 12'd1, 12'd1, 12'd0, 1'b0);
    send_word(OP_READ_WIRE, KIND_AND, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    send_word(OP_READ_WIRE, KIND_AND, 12'd1, 12'd0, 12'd0, 12'd0, 1'b0);
    send_word(OP_EVAL_GATE, KIND_XOR, 12'd2, 12'd1, 12'd3, 12'd0, 1'b0);
  endtask

  task automatic test_range_limits();
    send_word(OP_SET_INPUT, KIND_AND, 12'd0, 12'd0, 12'd0, 12'd4093, 1'b1);
    send_word(OP_SET_INPUT, KIND_AND, 12'd0, 12'd0, 12'd0, 12'd4094, 1'b1);
    send_word(OP_SET_INPUT, GATE_BAD_HI, 12'hFFF, 12'hFFF, 12'hFFF, 12'd4095, 1'b1);
    send_word(OP_READ_WIRE, KIND_AND, 12'd4095, 12'd0, 12'd0, 12'd0, 1'b0);
    send_word(OP_EVAL_GATE, KIND_AND, 12'd4095, 12'd4095, 12'd4095, 12'hFFF, 1'b1);
    set_wire_count(13'd3);
    send_word(OP_SET_INPUT, KIND_AND, 12'd0, 12'd0, 12'd0, 12'd1, 1'b1);
    send_word(OP_EVAL_GATE, GATE_BAD_HI, 12'd2, 12'd1, 12'd2, 12'd0, 1'b0);
    send_word(OP_EVAL_GATE, GATE_BAD_LO, 12'd2, 12'd1, 12'd3, 12'd0, 1'b0);
  endtask

  task automatic test_gate_kinds();
    set_wire_count(13'd4096);
    send_word(OP_EVAL_GATE, KIND_AND, 12'd1, 12'd1, 12'd5, 12'd0, 1'b0);
    send_word(OP_EVAL_GATE, KIND_XOR, 12'd1, 12'd5, 12'd6, 12'd0, 1'b0);
    send_word(OP_EVAL_GATE, GATE_BAD_LO, 12'd5, 12'd6, 12'd6, 12'd0, 1'b0);
    send_word(OP_UNDEFINED, GATE_BAD_HI, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1);
    send_word(OP_READ_WIRE, KIND_AND, 12'd6, 12'd0, 12'd0, 12'd0, 1'b0);
  endtask

  task automatic test_odd_wire_counts();
    set_wire_count(13'd0);
    send_word(OP_READ_WIRE, KIND_AND, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    send_word(OP_EVAL_GATE, KIND_AND, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    set_wire_count(13'd8191);
    send_word(OP_READ_WIRE, KIND_AND, 12'd4095, 12'd0, 12'd0, 12'd0, 1'b0);
    send_word(OP_SET_INPUT, KIND_AND, 12'd0, 12'd0, 12'd0, 12'd4095, 1'b0);
  endtask

  task automatic test_random_circuits();
    int counts [8];
    int sent;
    int n;
    counts = '{4096, 8191, 3, 4, 19, 200, 4095, 0};
    counts[7] = $urandom_range(3, 4096);
    foreach (counts[k]) begin
      set_wire_count(13'(counts[k]));
      sent = 0;
      while (sent < 180) begin
        choose_window();
        n = $urandom_range(20, 60);
        repeat (n) send_random_word($urandom_range(0, 9) == 0);
        sent += n;
        if ($urandom_range(0, 3) == 0) wait_results_drained();
      end
    end
  endtask

  task automatic test_full_rate_tail();
    set_wire_count(13'd40);
    idle_on = 1'b0;
    repeat (5) begin
      choose_window();
      repeat (50) send_random_word($urandom_range(0, 19) == 0);
    end
  endtask

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[0], out_tdata[1], out_tdata[2], out_tdata[3], out_tuser};
      if (pending_results.size() == 0) begin
        $error("unexpected result word: tdata %h, tuser %h", out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.bit_value !== want.bit_value) begin
          $error("bit_value: expected %0d, got %0d", want.bit_value, got.bit_value);
          mismatch_count++;
        end
        if (got.operand_a_bit !== want.operand_a_bit) begin
          $error("operand_a_bit: expected %0d, got %0d", want.operand_a_bit, got.operand_a_bit);
          mismatch_count++;
        end
        if (got.operand_b_bit !== want.operand_b_bit) begin
          $error("operand_b_bit: expected %0d, got %0d", want.operand_b_bit, got.operand_b_bit);
          mismatch_count++;
        end
        if (got.trace_and_bit !== want.trace_and_bit) begin
          $error("trace_and_bit: expected %0d, got %0d", want.trace_and_bit, got.trace_and_bit);
          mismatch_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    foreach (wire_store[w]) wire_store[w] = 1'b0;
    wire_store[WIRE_ONE] = 1'b1;
    wire_limit = WIRE_COUNT_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_constant_wires();
    test_range_limits();
    test_gate_kinds();
    test_odd_wire_counts();
    test_random_circuits();
    test_full_rate_tail();
    wait_results_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
